// ===== rtl/pbcs_pkg.sv =====
// Package for the blob centroid steering block: payload structs,
// register indexes, reset values and drive mode codes.
// No dependencies.
`default_nettype none

package pbcs_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] REG_MATCH_LEVEL   = 2'd1;
  localparam logic [1:0] REG_FORWARD_SPEED = 2'd2;
  localparam logic [1:0] REG_TURN_GAIN     = 2'd3;

  // Register reset values
  localparam logic [12:0] FRAME_WIDTH_RST   = 13'd640;
  localparam logic [7:0]  MATCH_LEVEL_RST   = 8'd255;
  localparam logic [15:0] FORWARD_SPEED_RST = 16'd1280;
  localparam logic [9:0]  TURN_GAIN_RST     = 10'd384;

  // Drive modes
  localparam logic [1:0] MODE_STOP    = 2'd0;
  localparam logic [1:0] MODE_FORWARD = 2'd1;
  localparam logic [1:0] MODE_TURN    = 2'd2;

  // Column counter can not exceed this many columns
  localparam int unsigned COL_LIMIT = 4096;

  // Saturating match counter limit
  localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       end_of_frame;
  } pixel_t;

  typedef struct packed {
    logic [1:0]         drive_mode;
    logic [15:0]        linear_speed;
    logic signed [15:0] turn_rate;
    logic               ball_found;
    logic [11:0]        ball_column;
  } result_t;

  // Per-frame totals handed from front to back
  typedef struct packed {
    logic [35:0] column_sum;
    logic [23:0] match_count;
  } frame_acc_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic valid;
    logic full;
  } queue_stat_t;

endpackage

`default_nettype wire

// ===== rtl/pbcs_front.sv =====
// Front end: column tracking, pixel match and per-frame accumulation.
// Depends on pbcs_pkg.
`default_nettype none

module pbcs_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire pbcs_pkg::pixel_t    in_data,
  input  wire logic [12:0]         width,
  input  wire logic [7:0]          match_level,
  input  wire logic                q_full,
  output logic                     q_push,
  output pbcs_pkg::frame_acc_t     q_wdata
);
  import pbcs_pkg::*;

  logic [11:0] col_r, col_nxt;
  logic [23:0] count_r, count_nxt;
  logic [35:0] sum_r, sum_nxt;
  logic [11:0] col;
  logic [12:0] col_inc;
  logic        hit;
  logic        accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Column of this pixel, wrapped if the width shrank
  assign col     = ({1'b0, col_r} >= width) ? 12'd0 : col_r;
  assign col_inc = {1'b0, col} + 13'd1;

  assign hit = (in_data.red == match_level) && (in_data.green == match_level) &&
               (in_data.blue == match_level) && (count_r != COUNT_MAX);

  // Accumulate, then clear after the end-of-frame pixel
  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    col_nxt   = col_r;
    if (accept) begin
      if (hit) begin
        count_nxt = count_r + 24'd1;
        sum_nxt   = sum_r + {24'd0, col};
      end
      if (in_data.end_of_frame) begin
        col_nxt = 12'd0;
      end else begin
        col_nxt = (col_inc >= width) ? 12'd0 : col_inc[11:0];
      end
    end
  end

  assign q_push              = accept && in_data.end_of_frame;
  assign q_wdata.column_sum  = sum_nxt;
  assign q_wdata.match_count = count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      count_r <= '0;
      sum_r   <= '0;
    end else if (q_push) begin
      col_r   <= '0;
      count_r <= '0;
      sum_r   <= '0;
    end else begin
      col_r   <= col_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pbcs_queue.sv =====
// Two-entry queue of frame totals between front and back end.
// Depends on pbcs_pkg.
`default_nettype none

module pbcs_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire pbcs_pkg::frame_acc_t  wdata,
  input  wire logic                  pop,
  output pbcs_pkg::frame_acc_t       rdata,
  output pbcs_pkg::queue_stat_t      stat
);
  import pbcs_pkg::*;

  frame_acc_t  entry_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  fill_r;

  assign rdata      = entry_r[rd_ptr_r];
  assign stat.valid = (fill_r != 2'd0);
  assign stat.full  = (fill_r == 2'd2);

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop)      fill_r <= fill_r + 2'd1;
      else if (pop && !push) fill_r <= fill_r - 2'd1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pbcs_back.sv =====
// Back end: centroid division, steering error, turn rate division with
// saturation, and the output register. One shared restoring divider.
// Depends on pbcs_pkg.
`default_nettype none

module pbcs_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire pbcs_pkg::queue_stat_t  q_stat,
  input  wire pbcs_pkg::frame_acc_t   q_rdata,
  output logic                        q_pop,
  input  wire logic [12:0]            width,
  input  wire logic [15:0]            forward_speed,
  input  wire logic [9:0]             turn_gain,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output pbcs_pkg::result_t           out_data
);
  import pbcs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV1 = 3'd1;
  localparam logic [2:0] S_ERR  = 3'd2;
  localparam logic [2:0] S_DIV2 = 3'd3;
  localparam logic [2:0] S_SAT  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [23:0] rem_r, rem_nxt;
  logic [35:0] dvd_r, dvd_nxt;
  logic [26:0] quo_r, quo_nxt;
  logic [23:0] divisor_r, divisor_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [11:0] mid_r, mid_nxt;
  logic        neg_r, neg_nxt;
  result_t     res_r, res_nxt;
  logic        out_valid_r;
  result_t     out_r;

  logic [24:0] shifted;
  logic        ge;
  logic [24:0] diff;
  logic [11:0] centre;
  logic [13:0] err;
  logic [12:0] mag;
  logic [22:0] prod;
  logic        load_out;

  // One restoring division step
  assign shifted = {rem_r, dvd_r[35]};
  assign ge      = (shifted >= {1'b0, divisor_r});
  assign diff    = shifted - {1'b0, divisor_r};

  // Steering error against the centre column
  assign centre = width[12:1];
  assign err    = {2'b00, quo_r[11:0]} - {2'b00, centre};
  assign mag    = err[13] ? 13'(-err) : err[12:0];
  assign prod   = mag * turn_gain;

  assign load_out = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign q_pop    = (state_r == S_IDLE) && q_stat.valid;

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    rem_nxt     = rem_r;
    dvd_nxt     = dvd_r;
    quo_nxt     = quo_r;
    divisor_nxt = divisor_r;
    step_nxt    = step_r;
    mid_nxt     = mid_r;
    neg_nxt     = neg_r;
    res_nxt     = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_stat.valid) begin
          if (q_rdata.match_count == 24'd0) begin
            res_nxt   = '0;
            res_nxt.drive_mode = MODE_STOP;
            state_nxt = S_DONE;
          end else begin
            // quotient is below 4096, so 12 steps suffice
            rem_nxt     = q_rdata.column_sum[35:12];
            dvd_nxt     = {q_rdata.column_sum[11:0], 24'd0};
            quo_nxt     = '0;
            divisor_nxt = q_rdata.match_count;
            step_nxt    = 5'd11;
            state_nxt   = S_DIV1;
          end
        end
      end
      S_DIV1, S_DIV2: begin
        rem_nxt  = ge ? diff[23:0] : shifted[23:0];
        dvd_nxt  = {dvd_r[34:0], 1'b0};
        quo_nxt  = {quo_r[25:0], ge};
        step_nxt = step_r - 5'd1;
        if (step_r == 5'd0) begin
          state_nxt = (state_r == S_DIV1) ? S_ERR : S_SAT;
        end
      end
      S_ERR: begin
        mid_nxt = quo_r[11:0];
        res_nxt = '0;
        res_nxt.ball_found  = 1'b1;
        res_nxt.ball_column = quo_r[11:0];
        if (err == 14'd0) begin
          res_nxt.drive_mode   = MODE_FORWARD;
          res_nxt.linear_speed = forward_speed;
          state_nxt = S_DONE;
        end else begin
          // |err| * gain * 32 fits 27 bits; divide by centre
          res_nxt.drive_mode = MODE_TURN;
          neg_nxt     = err[13];
          rem_nxt     = '0;
          dvd_nxt     = {prod[21:0], 5'd0, 9'd0};
          quo_nxt     = '0;
          divisor_nxt = {12'd0, centre};
          step_nxt    = 5'd26;
          state_nxt   = S_DIV2;
        end
      end
      S_SAT: begin
        if (neg_r) begin
          res_nxt.turn_rate = (quo_r > 27'd32768) ? 16'sh8000 : 16'(-quo_r[15:0]);
        end else begin
          res_nxt.turn_rate = (quo_r > 27'd32767) ? 16'sh7FFF : quo_r[15:0];
        end
        res_nxt.ball_column = mid_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    dvd_r     <= dvd_nxt;
    quo_r     <= quo_nxt;
    divisor_r <= divisor_nxt;
    step_r    <= step_nxt;
    mid_r     <= mid_nxt;
    neg_r     <= neg_nxt;
    res_r     <= res_nxt;
    if (load_out) out_r <= res_r;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out)       out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== rtl/pixel_blob_centroid_steer.sv =====
// Blob centroid steering: one pixel accepted per cycle unless the queue is
// full; one result per frame. An empty frame skips division, a centred blob
// takes the 12-step centroid division, a turn adds the 27-step turn division;
// both run on one shared restoring divider.
// A two-frame queue lets pixels keep flowing while the divider works.
// Synchronous active-low reset clears counters, queue, out_valid and config.
`default_nettype none

module pixel_blob_centroid_steer #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire pbcs_pkg::pixel_t   in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output pbcs_pkg::result_t       out_data,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import pbcs_pkg::*;

  localparam int WIDTH_HI = (MAX_WIDTH < COL_LIMIT) ? MAX_WIDTH : COL_LIMIT;

  logic [12:0] frame_width_r;
  logic [7:0]  match_level_r;
  logic [15:0] forward_speed_r;
  logic [9:0]  turn_gain_r;
  logic [12:0] width;

  logic        q_push, q_pop;
  frame_acc_t  q_wdata, q_rdata;
  queue_stat_t q_stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= FRAME_WIDTH_RST;
      match_level_r   <= MATCH_LEVEL_RST;
      forward_speed_r <= FORWARD_SPEED_RST;
      turn_gain_r     <= TURN_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:   frame_width_r   <= cfg_data[12:0];
        REG_MATCH_LEVEL:   match_level_r   <= cfg_data[7:0];
        REG_FORWARD_SPEED: forward_speed_r <= cfg_data;
        REG_TURN_GAIN:     turn_gain_r     <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Clamp width to the supported range
  always_comb begin
    width = frame_width_r;
    if (width < 13'd2) width = 13'd2;
    if (width > 13'(WIDTH_HI)) width = 13'(WIDTH_HI);
  end

  pbcs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .width       (width),
    .match_level (match_level_r),
    .q_full      (q_stat.full),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  pbcs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  pbcs_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .width         (width),
    .forward_speed (forward_speed_r),
    .turn_gain     (turn_gain_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/pbcs_checker.sv =====
// Port-level checks on the result channel of the steering block, and the
// bind that attaches them to the top level. Depends on pbcs_pkg.
`default_nettype none

module pbcs_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire pbcs_pkg::result_t out_data
);
  import pbcs_pkg::*;

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Stalled request holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Stop means nothing was found and nothing moves
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.drive_mode == MODE_STOP |->
      !out_data.ball_found && out_data.ball_column == 12'd0 &&
      out_data.linear_speed == 16'd0 && out_data.turn_rate == 16'sd0)
    else $error("stop result carries data");

  // Turning implies a find and no forward speed
  a_turn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.drive_mode == MODE_TURN |->
      out_data.ball_found && out_data.linear_speed == 16'd0)
    else $error("turn result inconsistent");

  // Forward has no turn component
  a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.drive_mode == MODE_FORWARD |->
      out_data.ball_found && out_data.turn_rate == 16'sd0)
    else $error("forward result inconsistent");

endmodule

bind pixel_blob_centroid_steer pbcs_checker u_pbcs_checker (.*);

`default_nettype wire

// ===== verif/steer_command_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the blob centroid steering block: watches the pixel, result
// and register ports, predicts one drive command per frame and compares.
// Depends on pbcs_pkg.
module steer_command_checker #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire pbcs_pkg::pixel_t  in_data,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire pbcs_pkg::result_t out_data,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_data,
  output int                     fail_count,
  output int                     pending
);
  import pbcs_pkg::*;

  localparam int unsigned WIDTH_CAP = (MAX_WIDTH < COL_LIMIT) ? MAX_WIDTH : COL_LIMIT;

  // Shadow copies of the registers
  logic [12:0] width_q;
  logic [7:0]  level_q;
  logic [15:0] speed_q;
  logic [9:0]  gain_q;

  // Frame accumulators
  logic [11:0] next_col;
  logic [23:0] hit_count;
  logic [35:0] hit_col_sum;

  result_t steer_expect_q[$];
  int      failures = 0;
  int      commands_checked = 0;

  // Row length actually used, after clamping the register
  function automatic int unsigned active_width();
    if (width_q < 13'd2) return 2;
    if (width_q > WIDTH_CAP) return WIDTH_CAP;
    return width_q;
  endfunction

  // Drive command from the totals of the frame just closed
  function automatic result_t steer_command(input int unsigned w);
    result_t cmd;
    longint  centre;
    longint  mid;
    longint  err;
    longint  rate;
    cmd = '0;
    cmd.drive_mode = MODE_STOP;
    if (hit_count != 0) begin
      centre = w / 2;
      mid = longint'(hit_col_sum / hit_count);
      err = mid - centre;
      cmd.ball_found = 1'b1;
      cmd.ball_column = mid[11:0];
      if (err == 0) begin
        cmd.drive_mode = MODE_FORWARD;
        cmd.linear_speed = speed_q;
      end else begin
        // err * gain / (2 * centre) in Q2.14, truncated toward zero
        rate = (err * longint'(gain_q) * 32) / centre;
        if (rate > 32767) rate = 32767;
        if (rate < -32768) rate = -32768;
        cmd.drive_mode = MODE_TURN;
        cmd.turn_rate = rate[15:0];
      end
    end
    return cmd;
  endfunction

  function automatic string command_text(input result_t c);
    return $sformatf("mode=%0d speed=%0d turn=%0d found=%0d column=%0d",
                     c.drive_mode, c.linear_speed, c.turn_rate, c.ball_found,
                     c.ball_column);
  endfunction

  // One accepted pixel request
  task automatic take_pixel(input pixel_t px);
    int unsigned w;
    logic [11:0] col;
    w = active_width();
    col = (next_col >= w) ? 12'd0 : next_col;
    // a full count freezes both count and sum for the rest of the frame
    if (px.red == level_q && px.green == level_q && px.blue == level_q &&
        hit_count != COUNT_MAX) begin
      hit_count = hit_count + 24'd1;
      hit_col_sum = hit_col_sum + col;
    end
    if (!px.end_of_frame) begin
      next_col = (int'(col) + 1 >= w) ? 12'd0 : col + 12'd1;
    end else begin
      steer_expect_q.push_back(steer_command(w));
      next_col = '0;
      hit_count = '0;
      hit_col_sum = '0;
    end
  endtask

  // One accepted result request against the oldest prediction
  task automatic check_result(input result_t got);
    result_t want;
    if (steer_expect_q.size() == 0) begin
      failures++;
      if (failures <= 10) $display("unexpected drive command: %s", command_text(got));
    end else begin
      want = steer_expect_q.pop_front();
      commands_checked++;
      if (got.drive_mode !== want.drive_mode || got.linear_speed !== want.linear_speed ||
          got.turn_rate !== want.turn_rate || got.ball_found !== want.ball_found ||
          got.ball_column !== want.ball_column) begin
        failures++;
        if (failures <= 10) begin
          $display("drive command %0d mismatch", commands_checked);
          $display("  expected %s", command_text(want));
          $display("  actual   %s", command_text(got));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_q = FRAME_WIDTH_RST;
      level_q = MATCH_LEVEL_RST;
      speed_q = FORWARD_SPEED_RST;
      gain_q = TURN_GAIN_RST;
      next_col = '0;
      hit_count = '0;
      hit_col_sum = '0;
      steer_expect_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:   width_q = cfg_data[12:0];
          REG_MATCH_LEVEL:   level_q = cfg_data[7:0];
          REG_FORWARD_SPEED: speed_q = cfg_data;
          REG_TURN_GAIN:     gain_q = cfg_data[9:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) take_pixel(in_data);
    end
    pending <= steer_expect_q.size();
    fail_count <= failures;
  end

endmodule

// ===== verif/pixel_blob_centroid_steer_test.sv =====
`timescale 1ns / 100ps
// Testbench top for pixel_blob_centroid_steer: clock, reset, register and
// pixel stimulus, result-side stall, watchdog and verdict.
// Depends on pbcs_pkg, pixel_blob_centroid_steer and steer_command_checker.
module pixel_blob_centroid_steer_test;
  import pbcs_pkg::*;

  localparam int MAX_WIDTH = 4096;
  localparam int unsigned RANDOM_PIXELS = 1050;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned ROW_WIDTH = 512;

  typedef enum int {FRAME_EMPTY, FRAME_SCATTER, FRAME_CENTRED, FRAME_EDGE} frame_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  pixel_t      in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  result_t     out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_FRAME_WIDTH;
  logic [15:0] cfg_data = '0;

  int          fail_count;
  int          pending;
  bit          calm = 1'b0;
  int unsigned stall_run = 0;
  int unsigned quiet = 0;
  int unsigned pixels_sent = 0;
  int unsigned cur_w = 640;
  logic [7:0]  cur_level = MATCH_LEVEL_RST;

  always #4 clk = ~clk;

  pixel_blob_centroid_steer #(
    .MAX_WIDTH(MAX_WIDTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  steer_command_checker #(
    .MAX_WIDTH(MAX_WIDTH)
  ) steer_check (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count),
    .pending(pending)
  );

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result-side back-pressure in random runs
  always @(posedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else begin
      out_stall <= ($urandom_range(2) == 0);
      stall_run <= gap_len();
    end
  end

  // Watchdog on cycles with no accepted request on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("pixel_blob_centroid_steer regression: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Hold one pixel request until it is taken
  task automatic push_pixel(input pixel_t px);
    int unsigned gap;
    gap = calm ? 0 : gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic push_rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                          input logic eof);
    pixel_t px;
    px.red = r;
    px.green = g;
    px.blue = b;
    px.end_of_frame = eof;
    push_pixel(px);
  endtask

  // Stop sending, wait for every predicted command, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all four registers in a rotated order from a random start while the block is idle
  task automatic program_regs(input logic [15:0] w, input logic [15:0] lvl,
                              input logic [15:0] spd, input logic [15:0] gain);
    logic [15:0] vals [4];
    int unsigned first;
    settle();
    vals[REG_FRAME_WIDTH] = w;
    vals[REG_MATCH_LEVEL] = lvl;
    vals[REG_FORWARD_SPEED] = spd;
    vals[REG_TURN_GAIN] = gain;
    first = $urandom_range(3);
    for (int unsigned k = 0; k < 4; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= 2'(first + k);
      cfg_data <= vals[2'(first + k)];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    if (w[12:0] < 13'd2) cur_w = 2;
    else if (w[12:0] > COL_LIMIT) cur_w = COL_LIMIT;
    else cur_w = w[12:0];
    cur_level = lvl[7:0];
  endtask

  function automatic pixel_t match_pixel();
    pixel_t px;
    px.red = cur_level;
    px.green = cur_level;
    px.blue = cur_level;
    px.end_of_frame = 1'b0;
    return px;
  endfunction

  // Never a match; half of them miss on one channel only
  function automatic pixel_t stray_pixel();
    pixel_t px;
    px = pixel_t'(25'($urandom));
    if ($urandom_range(1) == 1) begin
      px.red = cur_level;
      px.green = cur_level;
      px.blue = cur_level;
      case ($urandom_range(2))
        0: px.red = cur_level ^ 8'($urandom_range(1, 255));
        1: px.green = cur_level ^ 8'($urandom_range(1, 255));
        default: px.blue = cur_level ^ 8'($urandom_range(1, 255));
      endcase
    end
    if (px.red == cur_level && px.green == cur_level && px.blue == cur_level)
      px.red = ~cur_level;
    return px;
  endfunction

  task automatic run_frame(input int unsigned len, input frame_kind_t kind,
                           input int unsigned density);
    pixel_t px;
    int unsigned col;
    for (int unsigned i = 0; i < len; i++) begin
      col = i % cur_w;
      case (kind)
        FRAME_EMPTY:   px = stray_pixel();
        FRAME_CENTRED: px = (col == cur_w / 2 && $urandom_range(3) != 0) ?
                            match_pixel() : stray_pixel();
        FRAME_EDGE:    px = (col == cur_w - 1) ? match_pixel() : stray_pixel();
        default:       px = ($urandom_range(99) < density) ? match_pixel() : stray_pixel();
      endcase
      px.end_of_frame = (i == len - 1);
      push_pixel(px);
    end
  endtask

  // New register setting, then a handful of frames; small widths dominate
  task automatic random_phase();
    int unsigned pick;
    int unsigned len;
    logic [12:0] w;
    logic [7:0]  lvl;
    logic [9:0]  gain;
    frame_kind_t kind;
    pick = $urandom_range(99);
    if (pick < 5) w = 13'($urandom_range(1));
    else if (pick < 10) w = 13'($urandom_range(4097, 8191));
    else if (pick < 14) w = 13'(COL_LIMIT);
    else if (pick < 16) w = FRAME_WIDTH_RST;
    else w = 13'($urandom_range(2, 32));
    pick = $urandom_range(99);
    if (pick < 10) lvl = 8'd0;
    else if (pick < 20) lvl = 8'hFF;
    else lvl = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 10) gain = 10'd0;
    else if (pick < 20) gain = 10'd512;
    else if (pick < 25) gain = 10'h3FF;
    else gain = 10'($urandom_range(1, 512));
    program_regs({3'($urandom), w}, {8'($urandom), lvl}, 16'($urandom),
                 {6'($urandom), gain});
    calm <= ($urandom_range(4) == 0);
    repeat ($urandom_range(2, 8)) begin
      kind = frame_kind_t'($urandom_range(3));
      if (cur_w <= 32 && kind == FRAME_CENTRED) len = $urandom_range(cur_w / 2 + 1, cur_w * 3);
      else if (cur_w <= 32) len = $urandom_range(1, cur_w * 3);
      else len = $urandom_range(1, 48);
      if ($urandom_range(9) == 0) len = 1;
      run_frame(len, kind, $urandom_range(1, 60));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, lone non-matching end-of-frame pixel: stop
    push_rgb(8'h00, 8'h00, 8'h00, 1'b1);

    // Width 4, level 0x80, full speed, gain 2.0; upper data bits must be dropped
    program_regs(16'hE004, 16'hFF80, 16'hFFFF, 16'hFE00);
    // Matches at columns 1 and 3: centred, forward
    push_rgb(8'h80, 8'h7F, 8'h80, 1'b0);
    push_rgb(8'h80, 8'h80, 8'h80, 1'b0);
    push_rgb(8'h00, 8'h80, 8'h80, 1'b0);
    push_rgb(8'h80, 8'h80, 8'h80, 1'b1);
    // Column wraps back to 0 mid-frame: hard left
    push_rgb(8'h80, 8'h80, 8'h80, 1'b0);
    push_rgb(8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_rgb(8'h80, 8'h80, 8'h7F, 1'b0);
    push_rgb(8'h12, 8'h34, 8'h56, 1'b0);
    push_rgb(8'h80, 8'h80, 8'h80, 1'b0);
    push_rgb(8'hFF, 8'h00, 8'hFF, 1'b1);
    // Only the last column matches: right turn
    push_rgb(8'h00, 8'h00, 8'h00, 1'b0);
    push_rgb(8'h00, 8'h00, 8'h00, 1'b0);
    push_rgb(8'h00, 8'h00, 8'h00, 1'b0);
    push_rgb(8'h80, 8'h80, 8'h80, 1'b1);

    // Zero gain with an off-centre blob: still turn mode, rate zero
    program_regs(16'h0004, 16'h0080, 16'h0000, 16'h0000);
    push_rgb(8'h80, 8'h80, 8'h80, 1'b1);

    // Width 1 clamps to 2; largest gain
    program_regs(16'h0001, 16'h0080, 16'h1234, 16'h03FF);
    push_rgb(8'h80, 8'h80, 8'h80, 1'b0);
    push_rgb(8'h01, 8'h02, 8'h03, 1'b0);
    push_rgb(8'h80, 8'h80, 8'h80, 1'b1);

    // Width above the column limit clamps, which moves the centre
    program_regs(16'h1FFF, 16'h0000, 16'h8000, 16'h03FF);
    push_rgb(8'h01, 8'h00, 8'h00, 1'b0);
    push_rgb(8'h00, 8'h00, 8'h00, 1'b1);

    while (pixels_sent < RANDOM_PIXELS) random_phase();

    // One full row at a wide setting: column counter reaches the row end and wraps
    program_regs(16'(ROW_WIDTH), {8'($urandom), 8'($urandom)}, 16'($urandom), 16'd512);
    calm <= 1'b0;
    run_frame(ROW_WIDTH + 24, FRAME_EDGE, 0);

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("pixel_blob_centroid_steer regression: pass");
    end else begin
      $display("pixel_blob_centroid_steer regression: fail");
    end
    $finish;
  end

endmodule
